// ----- design/eps_bre_pkg.sv -----
// Shared constants and types for the EPS bearer bit rate encoder.
package eps_bre_pkg;

	localparam int RATE_W  = 40;
	localparam int QCI_W   = 8;
	localparam int CODE_W  = 8;
	// Bits 33:3 of the rate, enough for every rate below the saturation point.
	localparam int DIV_W   = 31;
	localparam int KBPS_W  = 25;

	// Smallest rate in bit/s whose kbit/s value exceeds 10000000.
	localparam logic [RATE_W-1:0] SAT_BPS = 40'd10000001000;

	// floor(2^38 / 125): the quotient it gives is exact or one short.
	localparam logic [31:0] RECIP_125   = 32'd2199023255;
	localparam int          RECIP_SHIFT = 38;
	localparam logic [7:0]  DIV_125     = 8'd125;

	// Octet codes with a special meaning.
	localparam logic [CODE_W-1:0] CODE_ZERO_RATE = 8'hff;
	localparam logic [CODE_W-1:0] CODE_BASE_ESC  = 8'hfe;
	localparam logic [CODE_W-1:0] CODE_EXT_ESC   = 8'hfa;
	localparam logic [CODE_W-1:0] CODE_EXT2_SAT  = 8'd246;

	// Range limits and origins in kbit/s.
	localparam logic [KBPS_W-1:0] KB_63      = 25'd63;
	localparam logic [KBPS_W-1:0] KB_64      = 25'd64;
	localparam logic [KBPS_W-1:0] KB_575     = 25'd575;
	localparam logic [KBPS_W-1:0] KB_576     = 25'd576;
	localparam logic [KBPS_W-1:0] KB_8600    = 25'd8600;
	localparam logic [KBPS_W-1:0] KB_8640    = 25'd8640;
	localparam logic [KBPS_W-1:0] KB_16000   = 25'd16000;
	localparam logic [KBPS_W-1:0] KB_128000  = 25'd128000;
	localparam logic [KBPS_W-1:0] KB_256000  = 25'd256000;
	localparam logic [KBPS_W-1:0] KB_500000  = 25'd500000;
	localparam logic [KBPS_W-1:0] KB_1500000 = 25'd1500000;

	typedef struct packed {
		logic              base_present;
		logic [CODE_W-1:0] base_code;
		logic              ext_present;
		logic [CODE_W-1:0] ext_code;
		logic              ext2_present;
		logic [CODE_W-1:0] ext2_code;
	} rate_code_t;

	typedef struct packed {
		logic             dflt;
		logic             sat;
		logic [QCI_W-1:0] qci;
	} item_meta_t;

endpackage

// ----- design/eps_bre_kbps.sv -----
// Two-stage conversion of a rate in units of 8 bit/s to kbit/s by reciprocal multiplication.
module eps_bre_kbps
	import eps_bre_pkg::*;
(
	input  logic              clk,
	input  logic [DIV_W-1:0]  div_in,
	output logic [KBPS_W-1:0] kbps
);

	logic [DIV_W+31:0]  prod;
	logic [DIV_W-1:0]   x_s2;
	logic [KBPS_W-1:0]  q0_s2;
	logic [31:0]        back;
	logic [31:0]        rem_full;
	logic [7:0]         rem;
	logic [KBPS_W-1:0]  kbps_s3;

	assign prod = {32'd0, div_in} * {{DIV_W{1'b0}}, RECIP_125};

	always_ff @(posedge clk) begin
		x_s2  <= div_in;
		q0_s2 <= prod[RECIP_SHIFT+KBPS_W-1:RECIP_SHIFT];
	end

	// The estimate is never high, so the remainder is below twice the divisor.
	assign back     = 32'(q0_s2) * 32'(DIV_125);
	assign rem_full = 32'(x_s2) - back;
	assign rem      = rem_full[7:0];

	always_ff @(posedge clk) begin
		if (rem >= DIV_125) begin
			kbps_s3 <= q0_s2 + KBPS_W'(1);
		end else begin
			kbps_s3 <= q0_s2;
		end
	end

	assign kbps = kbps_s3;

endmodule

// ----- design/eps_bre_quant.sv -----
// Stepped-range quantiser from kbit/s to the base, extended and extended-2 octets.
module eps_bre_quant
	import eps_bre_pkg::*;
(
	input  logic [KBPS_W-1:0] kbps,
	input  logic              sat,
	output rate_code_t        code
);

	logic [KBPS_W-1:0] d_b1, d_b2, d_e1, d_e2, d_e3, d_x1, d_x2, d_x3;
	logic [26:0] p_e1, p_e3, p_x1;
	logic [34:0] p_e2;
	logic [32:0] p_x2;
	logic [38:0] p_x3;
	logic [CODE_W-1:0] c_b1, c_b2, c_e1, c_e2, c_e3, c_x1, c_x2, c_x3;

	assign d_b1 = kbps - KB_64;
	assign d_b2 = kbps - KB_576;
	assign d_e1 = kbps - KB_8600;
	assign d_e2 = kbps - KB_16000;
	assign d_e3 = kbps - KB_128000;
	assign d_x1 = kbps - KB_256000;
	assign d_x2 = kbps - KB_500000;
	assign d_x3 = kbps - KB_1500000;

	// Each product is only used inside its own range, where the offset fits
	// the narrow slice taken here.
	assign p_e1 = 27'(d_e1[12:0]) * 27'd10486;
	assign p_e2 = 35'(d_e2[16:0]) * 35'd134218;
	assign p_e3 = 27'(d_e3[16:4]) * 27'd8389;
	assign p_x1 = 27'(d_x1[17:5]) * 27'd8389;
	assign p_x2 = 33'(d_x2[19:4]) * 33'd107375;
	assign p_x3 = 39'(d_x3[23:5]) * 39'd687195;

	assign c_b1 = 8'(d_b1[8:3]) + 8'd64;
	assign c_b2 = 8'(d_b2[12:6]) + 8'd128;
	assign c_e1 = 8'(p_e1[26:20]);
	assign c_e2 = p_e2[34:27] + 8'd74;
	assign c_e3 = 8'(p_e3[26:20]) + 8'd186;
	assign c_x1 = 8'(p_x1[26:20]);
	assign c_x2 = 8'(p_x2[32:26]) + 8'd61;
	assign c_x3 = p_x3[38:31] + 8'd161;

	always_comb begin
		code              = '0;
		code.base_present = 1'b1;
		if (sat) begin
			code.base_code    = CODE_BASE_ESC;
			code.ext_present  = 1'b1;
			code.ext_code     = CODE_EXT_ESC;
			code.ext2_present = 1'b1;
			code.ext2_code    = CODE_EXT2_SAT;
		end else if (kbps == '0) begin
			code.base_code = CODE_ZERO_RATE;
		end else if (kbps <= KB_63) begin
			code.base_code = kbps[CODE_W-1:0];
		end else if (kbps <= KB_575) begin
			code.base_code = c_b1;
		end else if (kbps <= KB_8640) begin
			code.base_code = c_b2;
		end else begin
			code.base_code   = CODE_BASE_ESC;
			code.ext_present = 1'b1;
			if (kbps <= KB_16000) begin
				code.ext_code = c_e1;
			end else if (kbps <= KB_128000) begin
				code.ext_code = c_e2;
			end else if (kbps <= KB_256000) begin
				code.ext_code = c_e3;
			end else begin
				code.ext_code     = CODE_EXT_ESC;
				code.ext2_present = 1'b1;
				if (kbps <= KB_500000) begin
					code.ext2_code = c_x1;
				end else if (kbps <= KB_1500000) begin
					code.ext2_code = c_x2;
				end else begin
					code.ext2_code = c_x3;
				end
			end
		end
	end

endmodule

// ----- design/eps_bit_rate_encoder_core.sv -----
// Top level of the EPS bearer bit rate encoder: input register, kbit/s pipeline, result register.
// The done strobe follows the valid flags through valid_s1, valid_s2, valid_s3 and done_q.
// Throughput: one item per clock cycle; busy is never raised, so start may be held high.
// Behind the input register the datapath has three stages: reciprocal multiply, quotient fix, quantiser.
// Reset clears every valid flag and the done strobe; payload registers are not reset.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module eps_bit_rate_encoder_core
	import eps_bre_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [RATE_W-1:0] rate_bps,
	input  logic              default_bearer,
	input  logic [QCI_W-1:0]  qci,
	output logic              done,
	output logic [QCI_W-1:0]  qci_out,
	output logic              base_present,
	output logic [CODE_W-1:0] base_code,
	output logic              ext_present,
	output logic [CODE_W-1:0] ext_code,
	output logic              ext2_present,
	output logic [CODE_W-1:0] ext2_code
);

	logic              valid_s1, valid_s2, valid_s3, done_q;
	logic [RATE_W-1:0] rate_s1;
	logic              dflt_s1;
	logic [QCI_W-1:0]  qci_s1;
	item_meta_t        meta_s2, meta_s3;
	logic [KBPS_W-1:0] kbps;
	rate_code_t        code;
	rate_code_t        code_q;
	logic [QCI_W-1:0]  qci_q;

	// Every cycle is free for a new item.
	assign busy = 1'b0;

	// Valid flags travel alongside the data so that idle cycles produce no strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		rate_s1 <= rate_bps;
		dflt_s1 <= default_bearer;
		qci_s1  <= qci;
	end

	// Saturation is decided on the full 40-bit rate here; above that point the
	// kbit/s pipeline only sees the low bits and its value is ignored.
	always_ff @(posedge clk) begin
		meta_s2.dflt <= dflt_s1;
		meta_s2.sat  <= (rate_s1 >= SAT_BPS);
		meta_s2.qci  <= qci_s1;
		meta_s3      <= meta_s2;
	end

	// Dividing by 8 first leaves a division by 125 for the multiplier.
	eps_bre_kbps u_kbps (
		.clk    (clk),
		.div_in (rate_s1[DIV_W+2:3]),
		.kbps   (kbps)
	);

	eps_bre_quant u_quant (
		.kbps (kbps),
		.sat  (meta_s3.sat),
		.code (code)
	);

	// A default bearer carries no rate octets at all, only its QCI.
	always_ff @(posedge clk) begin
		qci_q <= meta_s3.qci;
		if (meta_s3.dflt) begin
			code_q <= '0;
		end else begin
			code_q <= code;
		end
	end

	assign done         = done_q;
	assign qci_out      = qci_q;
	assign base_present = code_q.base_present;
	assign base_code    = code_q.base_code;
	assign ext_present  = code_q.ext_present;
	assign ext_code     = code_q.ext_code;
	assign ext2_present = code_q.ext2_present;
	assign ext2_code    = code_q.ext2_code;

endmodule

// ----- test/tb_eps_bit_rate_encoder_core.sv -----
// Self-checking testbench for the EPS bearer bit rate encoder core.
`timescale 1ns / 100ps

module tb_eps_bit_rate_encoder_core
	import eps_bre_pkg::*;
();

	// One expected or observed result of the encoder: the QCI and the three rate octets.
	typedef struct packed {
		logic [QCI_W-1:0] qci;
		rate_code_t       codes;
	} bearer_result_t;

	// Holds the results still owed by the block, oldest first, and checks each one that
	// comes out against the front of the queue.
	class rate_scoreboard;
		bearer_result_t owed_q[$];
		int unsigned    mismatches;

		// Encodes one bearer rate into its octets, with the rate floored to kbit/s.
		function automatic bearer_result_t encode_bearer_rate(logic [RATE_W-1:0] rate,
				logic dflt, logic [QCI_W-1:0] q);
			longint unsigned kb;
			longint unsigned b;
			longint unsigned e;
			longint unsigned e2;
			bearer_result_t  r;
			r = '0;
			r.qci = q;
			if (dflt) begin
				return r;
			end
			kb = 64'(rate);
			kb = kb / 1000;
			e = 0;
			e2 = 0;
			if (kb == 0) begin
				b = 64'(CODE_ZERO_RATE);
			end else if (kb <= 63) begin
				b = kb;
			end else if (kb <= 575) begin
				b = (kb - 64) / 8 + 64;
			end else if (kb <= 8640) begin
				b = (kb - 576) / 64 + 128;
			end else begin
				b = 64'(CODE_BASE_ESC);
				r.codes.ext_present = 1'b1;
				if (kb <= 16000) begin
					e = (kb - 8600) / 100;
				end else if (kb <= 128000) begin
					e = (kb - 16000) / 1000 + 74;
				end else if (kb <= 256000) begin
					e = (kb - 128000) / 2000 + 186;
				end else begin
					e = 64'(CODE_EXT_ESC);
					r.codes.ext2_present = 1'b1;
					if (kb <= 500000) begin
						e2 = (kb - 256000) / 4000;
					end else if (kb <= 1500000) begin
						e2 = (kb - 500000) / 10000 + 61;
					end else if (kb <= 10000000) begin
						e2 = (kb - 1500000) / 100000 + 161;
					end else begin
						e2 = 64'(CODE_EXT2_SAT);
					end
				end
			end
			r.codes.base_present = 1'b1;
			r.codes.base_code = b[CODE_W-1:0];
			r.codes.ext_code = e[CODE_W-1:0];
			r.codes.ext2_code = e2[CODE_W-1:0];
			return r;
		endfunction

		function void note_item(logic [RATE_W-1:0] rate, logic dflt, logic [QCI_W-1:0] q);
			owed_q.push_back(encode_bearer_rate(rate, dflt, q));
		endfunction

		function void check_result(bearer_result_t got);
			bearer_result_t exp;
			bit             ok;
			if (owed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing owed: qci %0d base %0d/%0d ext %0d/%0d ext2 %0d/%0d",
						$realtime, got.qci, got.codes.base_present, got.codes.base_code,
						got.codes.ext_present, got.codes.ext_code,
						got.codes.ext2_present, got.codes.ext2_code);
				return;
			end
			exp = owed_q.pop_front();
			ok = (got.qci === exp.qci)
				&& (got.codes.base_present === exp.codes.base_present)
				&& (got.codes.base_code === exp.codes.base_code)
				&& (got.codes.ext_present === exp.codes.ext_present)
				&& (got.codes.ext_code === exp.codes.ext_code)
				&& (got.codes.ext2_present === exp.codes.ext2_present)
				&& (got.codes.ext2_code === exp.codes.ext2_code);
			if (!ok) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch, expected qci %0d base %0d/%0d ext %0d/%0d ext2 %0d/%0d",
						$realtime, exp.qci, exp.codes.base_present, exp.codes.base_code,
						exp.codes.ext_present, exp.codes.ext_code,
						exp.codes.ext2_present, exp.codes.ext2_code);
					$display("%0t:           actual   qci %0d base %0d/%0d ext %0d/%0d ext2 %0d/%0d",
						$realtime, got.qci, got.codes.base_present, got.codes.base_code,
						got.codes.ext_present, got.codes.ext_code,
						got.codes.ext2_present, got.codes.ext2_code);
				end
			end
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		function bit failed();
			return (mismatches != 0) || (owed_q.size() != 0);
		endfunction
	endclass

	localparam int unsigned NUM_RANDOM_ITEMS = 2000;
	localparam longint unsigned RATE_MAX = 64'hff_ffff_ffff;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [RATE_W-1:0] rate_bps;
	logic              default_bearer;
	logic [QCI_W-1:0]  qci;
	logic              done;
	logic [QCI_W-1:0]  qci_out;
	logic              base_present;
	logic [CODE_W-1:0] base_code;
	logic              ext_present;
	logic [CODE_W-1:0] ext_code;
	logic              ext2_present;
	logic [CODE_W-1:0] ext2_code;

	rate_scoreboard rate_sb;

	// The kbit/s figures on either side of every range change in the three octets.
	// The random part aims at them, one kbit/s either side, as well as at the ranges.
	int unsigned range_limits[20] = '{0, 63, 64, 575, 576, 8600, 8640, 8641, 16000, 16001,
		128000, 128001, 256000, 256001, 500000, 500001, 1500000, 1500001, 10000000, 10000001};
	int unsigned region_lo[10] = '{0, 1, 64, 576, 8641, 16001, 128001, 256001, 500001, 1500001};
	int unsigned region_hi[10] = '{0, 63, 575, 8640, 16000, 128000, 256000, 500000, 1500000,
		10000000};

	eps_bit_rate_encoder_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.rate_bps       (rate_bps),
		.default_bearer (default_bearer),
		.qci            (qci),
		.done           (done),
		.qci_out        (qci_out),
		.base_present   (base_present),
		.base_code      (base_code),
		.ext_present    (ext_present),
		.ext_code       (ext_code),
		.ext2_present   (ext2_present),
		.ext2_code      (ext2_code)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Turns a kbit/s figure into a rate in bit/s with a random sub-kbit/s part. The sum is
	// clamped to the largest 40-bit rate, which no kbit/s figure used here comes near.
	function automatic logic [RATE_W-1:0] rate_from_kbps(longint unsigned kb);
		longint unsigned bps;
		bps = kb * 1000 + 64'($urandom_range(0, 999));
		if (bps > RATE_MAX)
			bps = RATE_MAX;
		return bps[RATE_W-1:0];
	endfunction

	// Chooses a random rate. Most picks land inside one quantiser range or right beside
	// a range limit, since that is where the arithmetic can go wrong; the rest are raw
	// 40-bit values, which keep every rate bit toggling and mostly hit saturation.
	function automatic logic [RATE_W-1:0] random_rate();
		int unsigned     sel;
		int unsigned     idx;
		longint unsigned kb;
		sel = $urandom_range(0, 9);
		if (sel <= 5) begin
			idx = $urandom_range(0, 9);
			kb = 64'($urandom_range(region_lo[idx], region_hi[idx]));
			return rate_from_kbps(kb);
		end else if (sel <= 7) begin
			idx = $urandom_range(0, 19);
			kb = 64'(range_limits[idx]);
			case ($urandom_range(0, 2))
				0: if (kb != 0) kb = kb - 1;
				1: kb = kb + 1;
				default: ;
			endcase
			return rate_from_kbps(kb);
		end else begin
			return {8'($urandom_range(0, 255)), $urandom()};
		end
	endfunction

	// Offers one item from a falling edge and holds it until a rising edge accepts it.
	// It returns on the falling edge after acceptance with start still high, so that a
	// following item can go out back to back without start dropping in between.
	task automatic send_item(logic [RATE_W-1:0] r, logic dflt, logic [QCI_W-1:0] q);
		bit taken;
		start = 1'b1;
		rate_bps = r;
		default_bearer = dflt;
		qci = q;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			if (!busy) begin
				rate_sb.note_item(r, dflt, q);
				taken = 1'b1;
			end
			@(negedge clk);
		end
	endtask

	// Drops start for a number of cycles. The payload is filled with junk meanwhile, which
	// the block must not take as an item.
	task automatic idle_cycles(int unsigned n);
		repeat (n) begin
			start = 1'b0;
			rate_bps = {8'($urandom_range(0, 255)), $urandom()};
			default_bearer = 1'($urandom_range(0, 1));
			qci = 8'($urandom_range(0, 255));
			@(negedge clk);
		end
	endtask

	// Holds off the next item until every owed result has come out.
	task automatic drain_results();
		start = 1'b0;
		while (rate_sb.pending() != 0)
			@(negedge clk);
	endtask

	// Mostly no gap or a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Every done strobe is one result, and it is sampled at the rising edge that ends
	// its cycle. The strobe is only trusted once reset has been let go.
	always @(posedge clk) begin
		bearer_result_t got;
		if (arst_n && done) begin
			got.qci = qci_out;
			got.codes.base_present = base_present;
			got.codes.base_code = base_code;
			got.codes.ext_present = ext_present;
			got.codes.ext_code = ext_code;
			got.codes.ext2_present = ext2_present;
			got.codes.ext2_code = ext2_code;
			rate_sb.check_result(got);
		end
	end

	// Watchdog. The slowest correct run is about 2000 items, each followed by the longest
	// gap; the limit below lies well beyond it.
	initial begin
		#5000000;
		$display("** eps_bit_rate_encoder_core: FAILED **");
		$finish;
	end

	initial begin
		logic [RATE_W-1:0] directed_rates[22];
		int unsigned       burst_left;
		int unsigned       i;

		rate_sb = new();
		start = 1'b0;
		rate_bps = '0;
		default_bearer = 1'b0;
		qci = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: both sides of every range limit, in bit/s, so that the floor to
		// kbit/s is tried as well; the zero rate; the saturation point; the largest rate.
		directed_rates = '{40'd0, 40'd999, 40'd1000, 40'd63999, 40'd64000, 40'd575999,
			40'd576000, 40'd8640999, 40'd8641000, 40'd16000999, 40'd16001000,
			40'd128000999, 40'd128001000, 40'd256000999, 40'd256001000, 40'd500000999,
			40'd500001000, 40'd1500000999, 40'd1500001000, 40'd10000000999,
			40'd10000001000, 40'hff_ffff_ffff};
		for (i = 0; i < 22; i++)
			send_item(directed_rates[i], 1'b0, i[QCI_W-1:0]);
		// A default bearer gives no rate octets, whatever the rate; the QCI still passes.
		send_item(40'hff_ffff_ffff, 1'b1, 8'hff);
		send_item(40'd0, 1'b1, 8'h00);
		send_item(40'd8641000, 1'b0, 8'hff);

		// Let the pipeline empty completely before the random part starts.
		drain_results();

		// Random part. Runs of back-to-back items alternate with random gaps, and the
		// sender waits for the block to run dry now and again.
		burst_left = 0;
		for (i = 0; i < NUM_RANDOM_ITEMS; i++) begin
			send_item(random_rate(), ($urandom_range(0, 9) == 0),
				8'($urandom_range(0, 255)));
			if (i % 500 == 499) begin
				drain_results();
			end else if (burst_left != 0) begin
				burst_left--;
			end else if ($urandom_range(0, 49) == 0) begin
				burst_left = $urandom_range(20, 80);
			end else begin
				idle_cycles(pick_gap());
			end
		end
		start = 1'b0;

		// Wait for the last results, then a few cycles more to catch any stray strobe.
		while (rate_sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (rate_sb.failed())
			$display("** eps_bit_rate_encoder_core: FAILED **");
		else
			$display("** eps_bit_rate_encoder_core: PASSED **");
		$finish;
	end

endmodule
